@@ sv/ota_image_receive_controller_unit_defines.svh @@
// ----------------------------------------------------------------------------
// OTA receive controller assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef OTA_IMAGE_RECEIVE_CONTROLLER_UNIT_DEFINES_SVH
`define OTA_IMAGE_RECEIVE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define OTARX_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OTARX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/otarx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otarx_pkg
// Types and constants of the OTA image receive controller.
// ----------------------------------------------------------------------------
package otarx_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam logic [31:0] OFFER_OVERHEAD = 32'd62;
  localparam logic [31:0] PARTITION_SIZE_RST = 32'd1048576;

  localparam logic [2:0] REQ_QUERY  = 3'd0;
  localparam logic [2:0] REQ_START  = 3'd1;
  localparam logic [2:0] REQ_DATA   = 3'd2;
  localparam logic [2:0] REQ_CHECK  = 3'd3;
  localparam logic [2:0] REQ_FINISH = 3'd4;
  localparam logic [2:0] REQ_ABORT  = 3'd5;
  localparam logic [2:0] REQ_OTHER  = 3'd6;

  localparam logic [1:0] CFG_PARTITION_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MAKER_CODE      = 2'd1;
  localparam logic [1:0] CFG_IMAGE_KIND      = 2'd2;
  localparam logic [1:0] CFG_RUNNING_VERSION = 2'd3;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_FAIL       = 4'd1,
    ST_BAD_STATE  = 4'd2,
    ST_UNSUPP     = 4'd3,
    ST_BAD_SIZE   = 4'd4,
    ST_NO_PART    = 4'd5,
    ST_BEGIN_FAIL = 4'd6,
    ST_INVALID    = 4'd7,
    ST_BOOT_FAIL  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    OP_IGNORE = 3'd0,
    OP_QUERY  = 3'd1,
    OP_START  = 3'd2,
    OP_DATA   = 3'd3,
    OP_CHECK  = 3'd4,
    OP_FINISH = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_FAIL   = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       found;
    logic       op_ok;
    logic       offer_ok;
    logic [7:0] data_byte;
    logic [6:0] left;
  } item_t;

endpackage

@@ sv/otarx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otarx interfaces
// Event channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface otarx_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic        msg_ok;
  logic        partition_found;
  logic        op_ok;
  logic [15:0] offer_maker;
  logic [15:0] offer_kind;
  logic [31:0] offer_version;
  logic [31:0] offer_size;
  logic [7:0]  data_byte;
  logic [6:0]  block_remaining;

  modport source (output valid, req_type, msg_ok, partition_found, op_ok, offer_maker,
                  offer_kind, offer_version, offer_size, data_byte, block_remaining,
                  input ready);
  modport sink (input valid, req_type, msg_ok, partition_found, op_ok, offer_maker,
                offer_kind, offer_version, offer_size, data_byte, block_remaining,
                output ready);
endinterface

interface otarx_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       write_valid;
  logic [7:0] write_byte;
  logic       abort_flash;
  logic       reboot_request;

  modport source (output valid, status, write_valid, write_byte, abort_flash,
                  reboot_request, input ready);
  modport sink (input valid, status, write_valid, write_byte, abort_flash,
                reboot_request, output ready);
endinterface

interface otarx_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/otarx_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otarx_front
// Holds the configuration registers, decodes each event, checks query offers
// and clamps the block count before the item enters the queue.
// ----------------------------------------------------------------------------
module otarx_front #(
  parameter int MAX_BLOCK = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  otarx_req_if.sink            req,
  otarx_cfg_if.sink            cfg,
  output logic                 push_valid,
  input  logic                 push_ready,
  output otarx_pkg::item_t     push_item,
  output logic [31:0]          partition_size
);
  import otarx_pkg::*;

  localparam logic [7:0] MaxBlk = 8'(MAX_BLOCK);

  logic [15:0] maker_code;
  logic [15:0] image_kind;
  logic [31:0] running_version;
  logic [31:0] size_net;
  logic        offer_ok;
  logic [6:0]  left;
  op_t         op;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_size  <= PARTITION_SIZE_RST;
      maker_code      <= '0;
      image_kind      <= '0;
      running_version <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PARTITION_SIZE:  partition_size  <= cfg.data;
        CFG_MAKER_CODE:      maker_code      <= cfg.data[15:0];
        CFG_IMAGE_KIND:      image_kind      <= cfg.data[15:0];
        CFG_RUNNING_VERSION: running_version <= cfg.data;
        default: ;
      endcase
    end
  end

  assign size_net = req.offer_size - OFFER_OVERHEAD;
  assign offer_ok = req.partition_found
                  && (req.offer_maker == maker_code)
                  && (req.offer_kind == image_kind)
                  && (req.offer_version > running_version)
                  && (req.offer_size > OFFER_OVERHEAD)
                  && (size_net <= partition_size);

  always_comb begin
    if (req.block_remaining == 7'd0) begin
      left = 7'd1;
    end else if ({1'b0, req.block_remaining} > MaxBlk) begin
      left = MaxBlk[6:0];
    end else begin
      left = req.block_remaining;
    end
  end

  always_comb begin
    unique case (req.req_type)
      REQ_QUERY:  op = req.msg_ok ? OP_QUERY  : OP_IGNORE;
      REQ_START:  op = req.msg_ok ? OP_START  : OP_FAIL;
      REQ_DATA:   op = req.msg_ok ? OP_DATA   : OP_FAIL;
      REQ_CHECK:  op = req.msg_ok ? OP_CHECK  : OP_FAIL;
      REQ_FINISH: op = req.msg_ok ? OP_FINISH : OP_FAIL;
      REQ_ABORT:  op = req.msg_ok ? OP_CLEAR  : OP_FAIL;
      REQ_OTHER:  op = req.msg_ok ? OP_IGNORE : OP_FAIL;
      default:    op = OP_IGNORE;
    endcase
  end

  assign push_valid          = req.valid;
  assign req.ready           = push_ready;
  assign push_item.op        = op;
  assign push_item.found     = req.partition_found;
  assign push_item.op_ok     = req.op_ok;
  assign push_item.offer_ok  = offer_ok;
  assign push_item.data_byte = req.data_byte;
  assign push_item.left      = left;

endmodule

@@ sv/otarx_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otarx_queue
// Two-entry queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module otarx_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  otarx_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output otarx_pkg::item_t pop_item
);
  import otarx_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ sv/otarx_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otarx_back
// Session state machine: executes one decoded item per cycle unless the sink
// holds back the pending result, and registers the result transaction.
// ----------------------------------------------------------------------------
module otarx_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  otarx_pkg::item_t pop_item,
  input  logic [31:0]      partition_size,
  otarx_rsp_if.source      rsp
);
  import otarx_pkg::*;
  `include "ota_image_receive_controller_unit_defines.svh"

  localparam logic [HDR_IDX_W-1:0] HdrLast = HDR_IDX_W'(HEADER_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] HdrFull = HDR_IDX_W'(HEADER_BYTES);

  logic                 session_active, session_active_next;
  logic                 image_checked, image_checked_next;
  logic                 partition_ready, partition_ready_next;
  logic [HDR_IDX_W-1:0] header_count, header_count_next;
  logic [31:0]          expected_length, expected_length_next;
  logic [31:0]          received_count, received_count_next;
  logic [7:0]           header_store [HEADER_BYTES];

  logic        adv;
  logic        hs_we;
  logic        do_clr;
  logic        set_sess;
  status_t     st;
  logic        wv;
  logic        ab;
  logic        rb;
  logic [31:0] len;
  logic [31:0] left32;

  assign adv       = pop_valid && (!rsp.valid || rsp.ready);
  assign pop_ready = adv;
  assign len       = {pop_item.data_byte, header_store[4], header_store[3], header_store[2]};
  assign left32    = {25'd0, pop_item.left};

  always_comb begin
    session_active_next  = session_active;
    image_checked_next   = image_checked;
    partition_ready_next = partition_ready;
    header_count_next    = header_count;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    st       = ST_OK;
    wv       = 1'b0;
    ab       = 1'b0;
    rb       = 1'b0;
    hs_we    = 1'b0;
    do_clr   = 1'b0;
    set_sess = 1'b0;
    unique case (pop_item.op)
      OP_IGNORE: ;
      OP_QUERY: begin
        if (session_active || !pop_item.offer_ok) st = ST_FAIL;
      end
      OP_FAIL: begin
        st     = ST_FAIL;
        do_clr = 1'b1;
        ab     = session_active;
      end
      OP_CLEAR: begin
        do_clr = 1'b1;
        ab     = session_active;
      end
      OP_START: begin
        do_clr = 1'b1;
        ab     = session_active;
        if (!pop_item.found) begin
          st = ST_NO_PART;
        end else if (pop_item.op_ok) begin
          set_sess = 1'b1;
        end else begin
          st = ST_BEGIN_FAIL;
        end
      end
      OP_DATA: begin
        if (!session_active || image_checked) begin
          st = ST_BAD_STATE;
        end else if (header_count < HdrFull) begin
          hs_we             = 1'b1;
          header_count_next = header_count + 1'b1;
          if (header_count == HdrLast && expected_length == 32'd0) begin
            if (header_store[0] != 8'd0 || header_store[1] != 8'd0) begin
              st = ST_UNSUPP;
            end else if (len == 32'd0 || len > partition_size) begin
              st = ST_BAD_SIZE;
            end else begin
              expected_length_next = len;
              if (left32 - 32'd1 > len - received_count) st = ST_BAD_SIZE;
            end
          end
        end else if (left32 > expected_length - received_count) begin
          st = ST_BAD_SIZE;
        end else begin
          wv                  = 1'b1;
          received_count_next = received_count + 32'd1;
        end
        if (st != ST_OK) begin
          do_clr = 1'b1;
          ab     = session_active;
        end
      end
      OP_CHECK: begin
        if (!session_active || expected_length == 32'd0 ||
            received_count != expected_length) begin
          st     = ST_BAD_SIZE;
          do_clr = 1'b1;
          ab     = session_active;
        end else begin
          session_active_next = 1'b0;
          image_checked_next  = pop_item.op_ok;
          if (!pop_item.op_ok) begin
            st     = ST_INVALID;
            do_clr = 1'b1;
          end
        end
      end
      OP_FINISH: begin
        if (!image_checked || !partition_ready) begin
          st     = ST_BAD_STATE;
          do_clr = 1'b1;
          ab     = session_active;
        end else if (pop_item.op_ok) begin
          rb = 1'b1;
        end else begin
          st     = ST_BOOT_FAIL;
          do_clr = 1'b1;
          ab     = session_active;
        end
      end
      default: ;
    endcase
    if (do_clr) begin
      session_active_next  = 1'b0;
      image_checked_next   = 1'b0;
      partition_ready_next = 1'b0;
      header_count_next    = '0;
      expected_length_next = '0;
      received_count_next  = '0;
    end
    if (set_sess) begin
      session_active_next  = 1'b1;
      partition_ready_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hs_we) begin
      header_store[header_count] <= pop_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      image_checked   <= 1'b0;
      partition_ready <= 1'b0;
      header_count    <= '0;
      expected_length <= '0;
      received_count  <= '0;
    end else if (adv) begin
      session_active  <= session_active_next;
      image_checked   <= image_checked_next;
      partition_ready <= partition_ready_next;
      header_count    <= header_count_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.status         <= st;
      rsp.write_valid    <= wv;
      rsp.write_byte     <= wv ? pop_item.data_byte : 8'd0;
      rsp.abort_flash    <= ab;
      rsp.reboot_request <= rb;
    end
  end

  `OTARX_ASSERT_HOLDS(a_write_clean, rsp.valid && rsp.write_valid, rsp.status == ST_OK && !rsp.abort_flash && !rsp.reboot_request, "flash write with error or side effect")
  `OTARX_ASSERT_HOLDS(a_abort_session, adv && ab, session_active, "abort requested without an active session")
  `OTARX_ASSERT_HOLDS(a_count_bound, session_active && header_count == HdrFull, received_count <= expected_length, "received count beyond expected length")
  `OTARX_ASSERT_NEXT(a_reboot_keeps, adv && rb, image_checked && partition_ready, "state lost after reboot request")

endmodule

@@ sv/ota_image_receive_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_image_receive_controller_unit
// Receive-side controller of an over-the-air firmware download.
// ----------------------------------------------------------------------------
// Takes one event or payload byte per cycle while the queue has room, and
// returns exactly one result transaction for each. The front decodes the
// event, checks query offers against the configuration registers and clamps
// the block count; a two-entry queue then feeds the session state machine,
// which executes one item per cycle into a registered result while the sink
// takes the results. Sustained rate is one transaction per cycle without
// back-pressure; each result passes through the queue slot written on
// acceptance and then the result register. Configuration writes are always
// accepted and must only be issued while the block is idle.
module ota_image_receive_controller_unit #(
  parameter int MAX_BLOCK = 64
) (
  input  logic        clk,
  input  logic        rst,
  otarx_req_if.sink   req,
  otarx_rsp_if.source rsp,
  otarx_cfg_if.sink   cfg
);
  import otarx_pkg::*;

  logic        push_valid;
  logic        push_ready;
  item_t       push_item;
  logic        pop_valid;
  logic        pop_ready;
  item_t       pop_item;
  logic [31:0] partition_size;

  otarx_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .cfg            (cfg),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item),
    .partition_size (partition_size)
  );

  otarx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  otarx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .partition_size (partition_size),
    .rsp            (rsp)
  );

endmodule

@@ test/ota_image_receive_controller_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_image_receive_controller_unit_tb
// Self-checking testbench of the OTA image receive controller.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own model of the download session and of the
// configuration registers. It predicts one result per accepted event and
// compares each returned result with the oldest prediction. A directed
// opening covers the query, start, header, payload, check and finish paths.
// It is followed by randomized download sessions with random faults mixed
// in, plus noise events. Both sides idle at random. The configuration is
// rewritten only once the block is idle.
module ota_image_receive_controller_unit_tb;
  import otarx_pkg::*;

  localparam int MAX_BLOCK = 64;
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int unsigned ITEM_TARGET = 1700;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 200;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        msg_ok;
    logic        found;
    logic        op_ok;
    logic [15:0] maker;
    logic [15:0] kind;
    logic [31:0] version;
    logic [31:0] size;
    logic [7:0]  data;
    logic [6:0]  left;
  } ota_event_t;

  typedef struct packed {
    status_t    status;
    logic       write_valid;
    logic [7:0] write_byte;
    logic       abort_flash;
    logic       reboot_request;
  } flash_result_t;

  class ota_session_scoreboard;
    logic [31:0] part_size;
    logic [31:0] maker_code;
    logic [31:0] kind_code;
    logic [31:0] run_version;
    logic        active;
    logic        img_checked;
    logic        part_ready;
    logic [7:0]  hdr [HEADER_BYTES];
    int unsigned hdr_cnt;
    logic [31:0] exp_len;
    logic [31:0] rcv_cnt;
    flash_result_t expected_results [$];
    int unsigned mismatches;
    int unsigned result_count;

    function new();
      part_size = PARTITION_SIZE_RST;
      maker_code = '0;
      kind_code = '0;
      run_version = '0;
      mismatches = 0;
      result_count = 0;
      void'(clear_session());
    endfunction

    function logic clear_session();
      logic was_active;
      was_active = active === 1'b1;
      active = 1'b0;
      img_checked = 1'b0;
      part_ready = 1'b0;
      for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'h00;
      hdr_cnt = 0;
      exp_len = '0;
      rcv_cnt = '0;
      return was_active;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_PARTITION_SIZE:  part_size = val;
        CFG_MAKER_CODE:      maker_code = {16'h0000, val[15:0]};
        CFG_IMAGE_KIND:      kind_code = {16'h0000, val[15:0]};
        CFG_RUNNING_VERSION: run_version = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_event(ota_event_t e);
      flash_result_t r;
      int unsigned lim;
      logic [31:0] len;
      r.status = ST_OK;
      r.write_valid = 1'b0;
      r.write_byte = 8'h00;
      r.abort_flash = 1'b0;
      r.reboot_request = 1'b0;
      lim = 32'(e.left);
      if (lim == 0) lim = 1;
      if (lim > MAX_BLOCK) lim = MAX_BLOCK;

      if (e.req_type == REQ_QUERY) begin
        if (e.msg_ok && (active || !e.found || e.maker != maker_code[15:0] ||
            e.kind != kind_code[15:0] || e.version <= run_version ||
            e.size <= OFFER_OVERHEAD || e.size - OFFER_OVERHEAD > part_size))
          r.status = ST_FAIL;
      end else if (e.req_type == REQ_UNUSED) begin
        r.status = ST_OK;
      end else if (!e.msg_ok) begin
        r.abort_flash = clear_session();
        r.status = ST_FAIL;
      end else if (e.req_type == REQ_START) begin
        r.abort_flash = clear_session();
        if (!e.found) begin
          r.status = ST_NO_PART;
        end else if (e.op_ok) begin
          part_ready = 1'b1;
          active = 1'b1;
        end else begin
          r.status = ST_BEGIN_FAIL;
          r.abort_flash = r.abort_flash | clear_session();
        end
      end else if (e.req_type == REQ_DATA) begin
        if (!active || img_checked) begin
          r.status = ST_BAD_STATE;
        end else if (hdr_cnt < HEADER_BYTES) begin
          hdr[hdr_cnt] = e.data;
          hdr_cnt++;
          if (hdr_cnt == HEADER_BYTES && exp_len == 0) begin
            len = {hdr[5], hdr[4], hdr[3], hdr[2]};
            if (hdr[0] != 8'h00 || hdr[1] != 8'h00) begin
              r.status = ST_UNSUPP;
            end else if (len == 0 || len > part_size) begin
              r.status = ST_BAD_SIZE;
            end else begin
              exp_len = len;
              if (lim - 1 > exp_len - rcv_cnt) r.status = ST_BAD_SIZE;
            end
          end
        end else if (lim > exp_len - rcv_cnt) begin
          r.status = ST_BAD_SIZE;
        end else begin
          r.write_valid = 1'b1;
          r.write_byte = e.data;
          rcv_cnt++;
        end
        if (r.status != ST_OK) r.abort_flash = clear_session();
      end else if (e.req_type == REQ_CHECK) begin
        if (!active || exp_len == 0 || rcv_cnt != exp_len) begin
          r.status = ST_BAD_SIZE;
          r.abort_flash = clear_session();
        end else begin
          active = 1'b0;
          img_checked = e.op_ok;
          if (!e.op_ok) begin
            r.status = ST_INVALID;
            r.abort_flash = clear_session();
          end
        end
      end else if (e.req_type == REQ_FINISH) begin
        if (!img_checked || !part_ready) begin
          r.status = ST_BAD_STATE;
          r.abort_flash = clear_session();
        end else if (e.op_ok) begin
          r.reboot_request = 1'b1;
        end else begin
          r.status = ST_BOOT_FAIL;
          r.abort_flash = clear_session();
        end
      end else if (e.req_type == REQ_ABORT) begin
        r.abort_flash = clear_session();
      end
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(flash_result_t got);
      flash_result_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no event pending", result_count));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  result_count, got.status, want.status));
      if (got.write_valid !== want.write_valid)
        report_mismatch($sformatf("result %0d write_valid %b, want %b",
                                  result_count, got.write_valid, want.write_valid));
      if (got.write_byte !== want.write_byte)
        report_mismatch($sformatf("result %0d write_byte %h, want %h",
                                  result_count, got.write_byte, want.write_byte));
      if (got.abort_flash !== want.abort_flash)
        report_mismatch($sformatf("result %0d abort_flash %b, want %b",
                                  result_count, got.abort_flash, want.abort_flash));
      if (got.reboot_request !== want.reboot_request)
        report_mismatch($sformatf("result %0d reboot_request %b, want %b",
                                  result_count, got.reboot_request, want.reboot_request));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  otarx_req_if req_if ();
  otarx_rsp_if rsp_if ();
  otarx_cfg_if cfg_if ();

  ota_session_scoreboard sb = new();

  bit no_idle = 1'b0;
  bit long_hold = 1'b0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  ota_image_receive_controller_unit #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    ota_event_t ev;
    flash_result_t res;
    if (!rst && req_if.valid && req_if.ready) begin
      ev.req_type = req_if.req_type;
      ev.msg_ok = req_if.msg_ok;
      ev.found = req_if.partition_found;
      ev.op_ok = req_if.op_ok;
      ev.maker = req_if.offer_maker;
      ev.kind = req_if.offer_kind;
      ev.version = req_if.offer_version;
      ev.size = req_if.offer_size;
      ev.data = req_if.data_byte;
      ev.left = req_if.block_remaining;
      sb.note_event(ev);
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      res.status = status_t'(rsp_if.status);
      res.write_valid = rsp_if.write_valid;
      res.write_byte = rsp_if.write_byte;
      res.abort_flash = rsp_if.abort_flash;
      res.reboot_request = rsp_if.reboot_request;
      sb.check_result(res);
    end
  end

  // watchdog: cycles without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(16, 0);
  endfunction

  initial begin : result_sink
    int unsigned stall;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = long_hold ? HOLD_CYCLES : idle_draw();
      long_hold = 1'b0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk);
    end
  end

  task automatic send_event(ota_event_t e);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.req_type <= e.req_type;
    req_if.msg_ok <= e.msg_ok;
    req_if.partition_found <= e.found;
    req_if.op_ok <= e.op_ok;
    req_if.offer_maker <= e.maker;
    req_if.offer_kind <= e.kind;
    req_if.offer_version <= e.version;
    req_if.offer_size <= e.size;
    req_if.data_byte <= e.data;
    req_if.block_remaining <= e.left;
    req_if.valid <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (e.req_type != REQ_UNUSED) items_sent++;
  endtask

  task automatic release_events();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  function automatic ota_event_t base_event(logic [2:0] req);
    ota_event_t e;
    e = '0;
    e.req_type = req;
    e.msg_ok = 1'b1;
    e.found = 1'b1;
    e.op_ok = 1'b1;
    e.left = 7'd1;
    return e;
  endfunction

  function automatic ota_event_t noise_event();
    ota_event_t e;
    e.req_type = 3'($urandom_range(7, 0));
    e.msg_ok = ($urandom_range(4, 0) != 0);
    e.found = 1'($urandom_range(1, 0));
    e.op_ok = 1'($urandom_range(1, 0));
    e.maker = $urandom_range(1, 0) ? sb.maker_code[15:0] : 16'($urandom);
    e.kind = $urandom_range(1, 0) ? sb.kind_code[15:0] : 16'($urandom);
    e.version = $urandom;
    e.size = $urandom;
    e.data = 8'($urandom);
    e.left = 7'($urandom_range(127, 0));
    return e;
  endfunction

  task automatic send_req(logic [2:0] req, logic ok, logic found, logic op_ok);
    ota_event_t e;
    e = base_event(req);
    e.msg_ok = ok;
    e.found = found;
    e.op_ok = op_ok;
    send_event(e);
  endtask

  task automatic send_query(logic ok, logic found, logic [15:0] maker, logic [15:0] kind,
                            logic [31:0] version, logic [31:0] size);
    ota_event_t e;
    e = base_event(REQ_QUERY);
    e.msg_ok = ok;
    e.found = found;
    e.maker = maker;
    e.kind = kind;
    e.version = version;
    e.size = size;
    send_event(e);
  endtask

  task automatic send_byte(logic [7:0] data, logic [6:0] left);
    ota_event_t e;
    e = base_event(REQ_DATA);
    e.data = data;
    e.left = left;
    send_event(e);
  endtask

  task automatic wait_idle();
    release_events();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.data <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(int unsigned sel);
    case (sel)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(400, 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic reconfigure(int unsigned phase);
    logic [31:0] v [4];
    int r;
    wait_idle();
    for (r = 0; r < 4; r++) begin
      if (phase == 1) v[r] = 32'h0000_0000;
      else if (phase == 2) v[r] = 32'hFFFF_FFFF;
      else v[r] = pick_value($urandom_range(3, 0));
    end
    write_reg(CFG_PARTITION_SIZE, v[0]);
    write_reg(CFG_MAKER_CODE, v[1]);
    write_reg(CFG_IMAGE_KIND, v[2]);
    write_reg(CFG_RUNNING_VERSION, v[3]);
  endtask

  // one download: query, start, header and payload in blocks, check, finish
  task automatic run_session();
    ota_event_t seq [$];
    ota_event_t e;
    logic [7:0] stream [$];
    logic [31:0] len;
    int unsigned cap, pos, blk, i, fault;
    cap = (sb.part_size == 0) ? 16 : ((sb.part_size < 80) ? sb.part_size : 80);
    len = $urandom_range(cap, 1);
    if ($urandom_range(9, 0) == 0 && sb.part_size >= 300) len = $urandom_range(300, 81);

    e = base_event(REQ_QUERY);
    e.maker = sb.maker_code[15:0];
    e.kind = sb.kind_code[15:0];
    e.version = sb.run_version + 1;
    e.size = 32'd63 + ($urandom % ((sb.part_size == 0) ? 32'd1 : sb.part_size));
    seq.push_back(e);
    seq.push_back(base_event(REQ_START));

    stream.push_back(8'h00);
    stream.push_back(8'h00);
    stream.push_back(len[7:0]);
    stream.push_back(len[15:8]);
    stream.push_back(len[23:16]);
    stream.push_back(len[31:24]);
    fault = $urandom_range(11, 0);
    if (fault == 0) stream[$urandom_range(1, 0)] = 8'($urandom_range(255, 1));
    else if (fault == 1) stream[5] = 8'($urandom_range(255, 1));
    else if (fault == 2) for (i = 2; i < 6; i++) stream[i] = 8'h00;
    for (i = 0; i < len; i++) stream.push_back(8'($urandom));

    pos = 0;
    while (pos < stream.size()) begin
      blk = $urandom_range(MAX_BLOCK, 1);
      if (blk > stream.size() - pos) blk = stream.size() - pos;
      for (i = 0; i < blk; i++) begin
        e = base_event(REQ_DATA);
        e.data = stream[pos + i];
        e.left = 7'(blk - i);
        seq.push_back(e);
      end
      pos += blk;
    end
    seq.push_back(base_event(REQ_CHECK));
    seq.push_back(base_event(REQ_FINISH));

    if ($urandom_range(2, 0) == 0) begin
      i = $urandom_range(seq.size() - 1, 0);
      case ($urandom_range(6, 0))
        0: seq[i].msg_ok = 1'b0;
        1: seq[i].op_ok = 1'b0;
        2: seq[i].left = 7'($urandom_range(127, 0));
        3: seq[i].data = 8'($urandom);
        4: seq.delete(i);
        5: seq.insert(i, noise_event());
        default: seq[i].found = 1'b0;
      endcase
    end

    foreach (seq[k]) send_event(seq[k]);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned sessions;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_QUERY;
    req_if.msg_ok = 1'b0;
    req_if.partition_found = 1'b0;
    req_if.op_ok = 1'b0;
    req_if.offer_maker = '0;
    req_if.offer_kind = '0;
    req_if.offer_version = '0;
    req_if.offer_size = '0;
    req_if.data_byte = '0;
    req_if.block_remaining = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_PARTITION_SIZE;
    cfg_if.data = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed opening on reset configuration
    send_req(REQ_UNUSED, 1'b0, 1'b0, 1'b0);
    send_query(1'b0, 1'b1, 16'h0000, 16'h0000, 32'd1, 32'd100);
    send_query(1'b1, 1'b1, 16'h0000, 16'h0000, 32'd1, 32'd63);
    send_query(1'b1, 1'b1, 16'h0000, 16'h0000, 32'd1, OFFER_OVERHEAD);
    send_query(1'b1, 1'b1, 16'h0000, 16'h0000, 32'd0, 32'd1000);
    send_query(1'b1, 1'b0, 16'h0000, 16'h0000, 32'd1, 32'd1000);
    send_query(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_query(1'b1, 1'b1, 16'h0000, 16'h0000, 32'hFFFF_FFFF,
               OFFER_OVERHEAD + PARTITION_SIZE_RST);
    send_query(1'b1, 1'b1, 16'h0000, 16'h0000, 32'd2,
               OFFER_OVERHEAD + PARTITION_SIZE_RST + 32'd1);
    send_req(REQ_FINISH, 1'b1, 1'b1, 1'b1);
    send_byte(8'hA5, 7'd1);
    send_req(REQ_START, 1'b1, 1'b0, 1'b1);
    send_req(REQ_START, 1'b1, 1'b1, 1'b0);
    send_req(REQ_START, 1'b0, 1'b1, 1'b1);
    send_req(REQ_START, 1'b1, 1'b1, 1'b1);
    // header: zero tag, length 2; first bytes carry out-of-range block counts
    send_byte(8'h00, 7'd0);
    send_byte(8'h00, 7'd127);
    send_byte(8'h02, 7'd6);
    send_byte(8'h00, 7'd5);
    send_byte(8'h00, 7'd4);
    send_byte(8'h00, 7'd3);
    send_byte(8'hFF, 7'd2);
    send_byte(8'h00, 7'd1);
    send_req(REQ_CHECK, 1'b1, 1'b1, 1'b1);
    send_req(REQ_FINISH, 1'b1, 1'b1, 1'b1);
    send_req(REQ_FINISH, 1'b1, 1'b1, 1'b1);
    send_req(REQ_OTHER, 1'b1, 1'b1, 1'b1);
    send_req(REQ_START, 1'b1, 1'b1, 1'b1);
    send_req(REQ_ABORT, 1'b1, 1'b1, 1'b1);
    send_req(REQ_OTHER, 1'b0, 1'b1, 1'b1);

    phase = 1;
    sessions = 0;
    reconfigure(phase);
    while (items_sent < ITEM_TARGET) begin
      if (sessions % 5 == 4) begin
        phase++;
        reconfigure(phase);
      end
      no_idle = ($urandom_range(3, 0) == 0);
      if (sessions == 9) begin
        no_idle = 1'b1;
        long_hold = 1'b1;
      end
      run_session();
      no_idle = 1'b0;
      repeat ($urandom_range(4, 0)) send_event(noise_event());
      sessions++;
    end

    release_events();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
